FILE: rtl/u8tc_pkg.sv
package u8tc_pkg;

	localparam int ADDR_W              = 3;
	localparam int DATA_W              = 32;
	localparam int QUEUE_DEPTH_DEFAULT = 2;
	localparam int MAX_BYTES           = 4;
	localparam int CNT_W               = 3;
	localparam int IDX_W               = 2;
	localparam int CP_W                = 21;

	localparam logic [ADDR_W-3:0] REG_SOURCE_ENCODING = '0;

	typedef enum logic [1:0] {
		ENC_PASS    = 2'd0,
		ENC_LATIN1  = 2'd1,
		ENC_UTF16LE = 2'd2,
		ENC_UTF16BE = 2'd3
	} enc_t;

	localparam logic [15:0]     UNIT_BOM    = 16'hFEFF;
	localparam logic [15:0]     HIGH_FIRST  = 16'hD800;
	localparam logic [15:0]     HIGH_LAST   = 16'hDBFF;
	localparam logic [15:0]     LOW_FIRST   = 16'hDC00;
	localparam logic [15:0]     LOW_LAST    = 16'hDFFF;
	localparam logic [CP_W-1:0] CP_REPLACE  = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_SUPP     = 21'h010000;
	localparam logic [CP_W-1:0] CP_MAX_1B   = 21'h00007F;
	localparam logic [CP_W-1:0] CP_MAX_2B   = 21'h0007FF;
	localparam logic [CP_W-1:0] CP_MAX_3B   = 21'h00FFFF;
	localparam logic [7:0]      CONT_MASK   = 8'h3F;
	localparam logic [7:0]      CONT_MARK   = 8'h80;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
		logic                      text_end;
	} entry_t;

endpackage

FILE: rtl/u8tc_front.sv
module u8tc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  u8tc_pkg::enc_t    enc,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              text_end,
	input  logic              q_full,
	output logic              push,
	output u8tc_pkg::entry_t  entry
);

	logic                           odd_q, odd_n;
	logic [7:0]                     held_q, held_n;
	logic                           hp_q, hp_n;
	logic [9:0]                     payload_q, payload_n;
	logic                           start_q, start_n;
	logic                           emit, raw;
	logic [u8tc_pkg::CP_W-1:0]      cp;
	logic [15:0]                    w;
	logic                           is_high, is_low;
	logic                           accept;

	function automatic u8tc_pkg::entry_t encode(input logic [u8tc_pkg::CP_W-1:0] c);
		u8tc_pkg::entry_t e;
		e = '0;
		if (c <= u8tc_pkg::CP_MAX_1B) begin
			e.bytes[0] = c[7:0];
			e.cnt      = 3'd1;
		end else if (c <= u8tc_pkg::CP_MAX_2B) begin
			e.bytes[0] = {3'b110, c[10:6]};
			e.bytes[1] = u8tc_pkg::CONT_MARK | ({2'b00, c[5:0]} & u8tc_pkg::CONT_MASK);
			e.cnt      = 3'd2;
		end else if (c <= u8tc_pkg::CP_MAX_3B) begin
			e.bytes[0] = {4'b1110, c[15:12]};
			e.bytes[1] = u8tc_pkg::CONT_MARK | {2'b00, c[11:6]};
			e.bytes[2] = u8tc_pkg::CONT_MARK | {2'b00, c[5:0]};
			e.cnt      = 3'd3;
		end else begin
			e.bytes[0] = {5'b11110, c[20:18]};
			e.bytes[1] = u8tc_pkg::CONT_MARK | {2'b00, c[17:12]};
			e.bytes[2] = u8tc_pkg::CONT_MARK | {2'b00, c[11:6]};
			e.bytes[3] = u8tc_pkg::CONT_MARK | {2'b00, c[5:0]};
			e.cnt      = 3'd4;
		end
		return e;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign w       = (enc == u8tc_pkg::ENC_UTF16LE) ? {in_byte, held_q} : {held_q, in_byte};
	assign is_high = (w >= u8tc_pkg::HIGH_FIRST) && (w <= u8tc_pkg::HIGH_LAST);
	assign is_low  = (w >= u8tc_pkg::LOW_FIRST) && (w <= u8tc_pkg::LOW_LAST);

	always_comb begin
		odd_n     = odd_q;
		held_n    = held_q;
		hp_n      = hp_q;
		payload_n = payload_q;
		start_n   = start_q;
		emit      = 1'b0;
		raw       = 1'b0;
		cp        = '0;
		unique case (enc)
			u8tc_pkg::ENC_PASS: begin
				raw = 1'b1;
			end
			u8tc_pkg::ENC_LATIN1: begin
				emit = 1'b1;
				cp   = {13'b0, in_byte};
			end
			u8tc_pkg::ENC_UTF16LE, u8tc_pkg::ENC_UTF16BE: begin
				if (!odd_q) begin
					odd_n  = 1'b1;
					held_n = in_byte;
				end else begin
					odd_n   = 1'b0;
					held_n  = '0;
					start_n = 1'b0;
					if (start_q && (w == u8tc_pkg::UNIT_BOM)) begin
						emit = 1'b0;
					end else if (hp_q) begin
						hp_n = 1'b0;
						emit = 1'b1;
						if (is_low) begin
							cp = u8tc_pkg::CP_SUPP + {1'b0, payload_q, w[9:0]};
						end else begin
							cp = u8tc_pkg::CP_REPLACE;
						end
					end else if (is_high) begin
						hp_n      = 1'b1;
						payload_n = w[9:0];
					end else if (is_low) begin
						emit = 1'b1;
						cp   = u8tc_pkg::CP_REPLACE;
					end else begin
						emit = 1'b1;
						cp   = {5'b0, w};
					end
				end
				// A high surrogate still open at the end of the text is closed
				// with a replacement character; nothing else is emitted then.
				if (text_end && hp_n) begin
					emit = 1'b1;
					cp   = u8tc_pkg::CP_REPLACE;
				end
			end
			default: begin
				raw = 1'b1;
			end
		endcase
		if (text_end) begin
			odd_n     = 1'b0;
			held_n    = '0;
			hp_n      = 1'b0;
			payload_n = '0;
			start_n   = 1'b1;
		end
	end

	always_comb begin
		if (raw) begin
			entry          = '0;
			entry.bytes[0] = in_byte;
			entry.cnt      = 3'd1;
		end else if (emit) begin
			entry = encode(cp);
		end else begin
			entry = '0;
		end
		entry.text_end = text_end;
	end

	assign push = accept && ((entry.cnt != '0) || text_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q     <= 1'b0;
			held_q    <= '0;
			hp_q      <= 1'b0;
			payload_q <= '0;
			start_q   <= 1'b1;
		end else if (accept) begin
			odd_q     <= odd_n;
			held_q    <= held_n;
			hp_q      <= hp_n;
			payload_q <= payload_n;
			start_q   <= start_n;
		end
	end

endmodule

FILE: rtl/u8tc_queue.sv
module u8tc_queue #(
	parameter int DEPTH = u8tc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8tc_pkg::entry_t  wr_entry,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output u8tc_pkg::entry_t  rd_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	u8tc_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/u8tc_back.sv
module u8tc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  u8tc_pkg::entry_t  q_entry,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              last_of_run,
	output logic              text_done
);

	u8tc_pkg::entry_t                cur_q;
	logic                            busy_q;
	logic [u8tc_pkg::IDX_W-1:0]      idx_q;
	logic                            is_last;
	logic                            fire;
	logic                            load;

	assign is_last     = (cur_q.cnt == '0) || ({1'b0, idx_q} == cur_q.cnt - 1'b1);
	assign out_valid   = busy_q;
	assign byte_valid  = (cur_q.cnt != '0);
	assign out_byte    = byte_valid ? cur_q.bytes[idx_q] : 8'h00;
	assign last_of_run = is_last;
	assign text_done   = is_last && cur_q.text_end;

	assign fire  = out_valid && out_ready;
	assign load  = !busy_q || (fire && is_last);
	assign q_pop = load && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= !q_empty;
			idx_q  <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
	end

`ifndef NO_ASSERTIONS
	a_empty_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (last_of_run && text_done))
		else $error("empty marker is not the final transaction of a text");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && text_done) |-> last_of_run)
		else $error("text_done without last_of_run");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (cur_q.cnt != '0)) |-> ({1'b0, idx_q} < cur_q.cnt))
		else $error("byte index beyond the entry's byte count");
	a_step_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !is_last) |=> (busy_q && (idx_q == $past(idx_q) + 1'b1)))
		else $error("byte index did not advance after a transaction");
`endif

endmodule

FILE: rtl/utf16_latin1_to_utf8_transcoder.sv
// Channel  Direction  Handshake            Payload
// input    in         in_valid/in_ready    in_byte, text_end
// output   out        out_valid/out_ready  out_byte, byte_valid, last_of_run, text_done
// config   in         APB psel/penable     paddr, pwdata, prdata (source_encoding at 0)
//
// An input transaction is accepted in any cycle in which the queue has room.
// Output bytes leave one a cycle while out_ready is high and the queue is not empty; an item
// yields up to four UTF-8 bytes (two for Latin-1 above 0x7F), else an empty end marker or nothing.
// Reset is asynchronous and active low; the encoding returns to pass-through.
// A stalled output holds its byte; the queue of QUEUE_DEPTH entries then fills and
// in_ready falls until the serialiser drains it.
module utf16_latin1_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = u8tc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [u8tc_pkg::ADDR_W-1:0] paddr,
	input  logic [u8tc_pkg::DATA_W-1:0] pwdata,
	output logic [u8tc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	input  logic                        text_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        byte_valid,
	output logic                        last_of_run,
	output logic                        text_done
);

	u8tc_pkg::enc_t    enc_q;
	u8tc_pkg::entry_t  push_entry, head_entry;
	logic              push, pop, q_full, q_empty;
	logic              reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[u8tc_pkg::ADDR_W-1:2] == u8tc_pkg::REG_SOURCE_ENCODING);
	assign prdata  = reg_hit ? {{(u8tc_pkg::DATA_W-2){1'b0}}, enc_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q <= u8tc_pkg::ENC_PASS;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			enc_q <= u8tc_pkg::enc_t'(pwdata[1:0]);
		end
	end

	u8tc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enc      (enc_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.text_end (text_end),
		.q_full   (q_full),
		.push     (push),
		.entry    (push_entry)
	);

	u8tc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.rd_entry (head_entry)
	);

	u8tc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_entry     (head_entry),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.text_done   (text_done)
	);

endmodule

FILE: dv/tb_utf16_latin1_to_utf8_transcoder.sv
typedef struct packed {
	logic [7:0] data;
	logic       valid;
	logic       last;
	logic       done;
} utf8_beat_t;

// Predicts the UTF-8 beats of every accepted input transaction and checks the output stream.
class utf8_scoreboard;
	u8tc_pkg::enc_t encoding;
	bit             odd_held;
	logic [7:0]     held;
	bit             high_wait;
	logic [9:0]     high_bits;
	bit             text_start;
	logic [7:0]     staged[$];
	utf8_beat_t     expected_q[$];
	int unsigned    mismatches;

	function new();
		encoding   = u8tc_pkg::ENC_PASS;
		mismatches = 0;
		clear_text();
	endfunction

	function void clear_text();
		odd_held   = 0;
		held       = '0;
		high_wait  = 0;
		high_bits  = '0;
		text_start = 1;
	endfunction

	function void set_encoding(logic [31:0] value);
		encoding = u8tc_pkg::enc_t'(value[1:0]);
	endfunction

	function void stage(logic [7:0] b);
		staged.insert(staged.size(), b);
	endfunction

	function void expect_beat(logic [7:0] d, logic v, logic l, logic f);
		utf8_beat_t beat;
		beat.data  = d;
		beat.valid = v;
		beat.last  = l;
		beat.done  = f;
		expected_q.insert(expected_q.size(), beat);
	endfunction

	function void emit_code_point(logic [20:0] cp);
		if (cp <= u8tc_pkg::CP_MAX_1B) begin
			stage(cp[7:0]);
		end else if (cp <= u8tc_pkg::CP_MAX_2B) begin
			stage({3'b110, cp[10:6]});
			stage({2'b10, cp[5:0]});
		end else if (cp <= u8tc_pkg::CP_MAX_3B) begin
			stage({4'b1110, cp[15:12]});
			stage({2'b10, cp[11:6]});
			stage({2'b10, cp[5:0]});
		end else begin
			stage({5'b11110, cp[20:18]});
			stage({2'b10, cp[17:12]});
			stage({2'b10, cp[11:6]});
			stage({2'b10, cp[5:0]});
		end
	endfunction

	function void decode_unit(logic [15:0] w);
		bit is_high;
		bit is_low;
		is_high = (w >= u8tc_pkg::HIGH_FIRST) && (w <= u8tc_pkg::HIGH_LAST);
		is_low  = (w >= u8tc_pkg::LOW_FIRST) && (w <= u8tc_pkg::LOW_LAST);
		if (text_start) begin
			text_start = 0;
			if (w == u8tc_pkg::UNIT_BOM)
				return;
		end
		if (high_wait) begin
			high_wait = 0;
			if (is_low)
				emit_code_point(u8tc_pkg::CP_SUPP + {1'b0, high_bits, w[9:0]});
			else
				emit_code_point(u8tc_pkg::CP_REPLACE);
			return;
		end
		if (is_high) begin
			high_wait = 1;
			high_bits = w[9:0];
		end else if (is_low) begin
			emit_code_point(u8tc_pkg::CP_REPLACE);
		end else begin
			emit_code_point({5'b0, w});
		end
	endfunction

	function void note_input(logic [7:0] b, logic fin);
		logic [15:0] w;
		int          n;
		staged.delete();
		case (encoding)
			u8tc_pkg::ENC_PASS: begin
				stage(b);
			end
			u8tc_pkg::ENC_LATIN1: begin
				emit_code_point({13'b0, b});
			end
			default: begin
				if (!odd_held) begin
					odd_held = 1;
					held     = b;
				end else begin
					w        = (encoding == u8tc_pkg::ENC_UTF16LE) ? {b, held} : {held, b};
					odd_held = 0;
					held     = '0;
					decode_unit(w);
				end
				if (fin && high_wait)
					emit_code_point(u8tc_pkg::CP_REPLACE);
			end
		endcase
		if (fin)
			clear_text();
		n = staged.size();
		if (n == 0) begin
			if (fin)
				expect_beat(8'h00, 1'b0, 1'b1, 1'b1);
			return;
		end
		for (int k = 0; k < n; k++)
			expect_beat(staged[k], 1'b1, k == n - 1, (k == n - 1) && fin);
	endfunction

	function void check_result(logic [7:0] ob, logic bv, logic lr, logic td);
		utf8_beat_t want;
		if (expected_q.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected beat: byte %02h valid %0b last %0b done %0b",
					ob, bv, lr, td);
			mismatches++;
			return;
		end
		want = expected_q.pop_front();
		if (want.data !== ob || want.valid !== bv || want.last !== lr || want.done !== td) begin
			if (mismatches < 10)
				$display("mismatch: expected byte %02h valid %0b last %0b done %0b,",
					want.data, want.valid, want.last, want.done,
					" got byte %02h valid %0b last %0b done %0b", ob, bv, lr, td);
			mismatches++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_utf16_latin1_to_utf8_transcoder;

	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_ITEMS   = 330;
	localparam int CYCLE_LIMIT  = 300000;
	localparam logic [u8tc_pkg::ADDR_W-1:0] ENC_ADDR   = {u8tc_pkg::REG_SOURCE_ENCODING, 2'b00};
	localparam logic [u8tc_pkg::ADDR_W-1:0] BLANK_ADDR = ENC_ADDR + u8tc_pkg::ADDR_W'(4);
	localparam logic [7:0] LE_SEQ [16] = '{8'hFF, 8'hFE, 8'h3D, 8'hD8, 8'h00, 8'hDE,
		8'h00, 8'hDC, 8'hFF, 8'h07, 8'h00, 8'hD8, 8'h41, 8'h00, 8'h00, 8'hDB};

	logic                        clk      = 1'b0;
	logic                        arst_n   = 1'b0;
	logic                        psel     = 1'b0;
	logic                        penable  = 1'b0;
	logic                        pwrite   = 1'b0;
	logic [u8tc_pkg::ADDR_W-1:0] paddr    = '0;
	logic [u8tc_pkg::DATA_W-1:0] pwdata   = '0;
	logic [u8tc_pkg::DATA_W-1:0] prdata;
	logic                        pready;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [7:0]                  in_byte  = '0;
	logic                        text_end = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [7:0]                  out_byte;
	logic                        byte_valid;
	logic                        last_of_run;
	logic                        text_done;

	utf8_scoreboard sb;
	u8tc_pkg::enc_t cur_enc    = u8tc_pkg::ENC_PASS;
	int             items_sent = 0;
	int             idle_pct   = 0;
	bit             calm       = 0;
	int             stall_left = 0;
	int             cycle_count = 0;

	utf16_latin1_to_utf8_transcoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.text_end    (text_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.text_done   (text_done)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_utf16_latin1_to_utf8_transcoder: done, errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (!calm && $urandom_range(0, 99) < idle_pct / 2)
			stall_left = $urandom_range(1, 14);
		out_ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(out_byte, byte_valid, last_of_run, text_done);
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte  <= b;
		text_end <= fin;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b, fin);
		items_sent++;
	endtask

	// Waits until every predicted beat has been checked, then adds a pause; inputs that yield no beat are never queued.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [u8tc_pkg::ADDR_W-1:0] addr,
		input logic [u8tc_pkg::DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ENC_ADDR)
			sb.set_encoding(data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_utf16_text(input bit finish);
		logic [15:0] units[$];
		logic [7:0]  bytes[$];
		logic [15:0] u;
		int          count;
		int          kind;
		if ($urandom_range(0, 2) == 0)
			units.insert(units.size(), u8tc_pkg::UNIT_BOM);
		count = $urandom_range(1, 8);
		repeat (count) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0: units.insert(units.size(), 16'($urandom_range(0, 'h7F)));
				1: units.insert(units.size(), 16'($urandom_range('h80, 'h7FF)));
				2: begin
					if ($urandom_range(0, 1))
						u = 16'($urandom_range('h800, 'hD7FF));
					else
						u = 16'($urandom_range('hE000, 'hFFFF));
					units.insert(units.size(), u);
				end
				3, 4: begin
					u = 16'($urandom_range(u8tc_pkg::HIGH_FIRST, u8tc_pkg::HIGH_LAST));
					units.insert(units.size(), u);
					u = 16'($urandom_range(u8tc_pkg::LOW_FIRST, u8tc_pkg::LOW_LAST));
					units.insert(units.size(), u);
				end
				5: units.insert(units.size(), u8tc_pkg::UNIT_BOM);
				6: begin
					u = 16'($urandom_range(u8tc_pkg::LOW_FIRST, u8tc_pkg::LOW_LAST));
					units.insert(units.size(), u);
				end
				7: begin
					u = 16'($urandom_range(u8tc_pkg::HIGH_FIRST, u8tc_pkg::HIGH_LAST));
					units.insert(units.size(), u);
				end
				8: units.insert(units.size(), 16'($urandom));
				default: begin
					case ($urandom_range(0, 5))
						0: units.insert(units.size(), 16'h0000);
						1: units.insert(units.size(), 16'hFFFF);
						2: units.insert(units.size(), u8tc_pkg::HIGH_FIRST);
						3: units.insert(units.size(), u8tc_pkg::HIGH_LAST);
						4: units.insert(units.size(), u8tc_pkg::LOW_FIRST);
						default: units.insert(units.size(), u8tc_pkg::LOW_LAST);
					endcase
				end
			endcase
		end
		foreach (units[i]) begin
			if (cur_enc == u8tc_pkg::ENC_UTF16LE) begin
				bytes.insert(bytes.size(), units[i][7:0]);
				bytes.insert(bytes.size(), units[i][15:8]);
			end else begin
				bytes.insert(bytes.size(), units[i][15:8]);
				bytes.insert(bytes.size(), units[i][7:0]);
			end
		end
		if ($urandom_range(0, 4) == 0)
			bytes.insert(bytes.size(), 8'($urandom));
		foreach (bytes[i])
			send_byte(bytes[i], finish && (i == bytes.size() - 1));
	endtask

	task automatic send_byte_text(input bit finish);
		int count;
		count = $urandom_range(1, 12);
		for (int i = 0; i < count; i++)
			send_byte(8'($urandom), finish && (i == count - 1));
	endtask

	initial begin
		int             random_start;
		int             phase;
		int             texts;
		u8tc_pkg::enc_t mode;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		write_reg(ENC_ADDR, u8tc_pkg::DATA_W'(u8tc_pkg::ENC_PASS));
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();
		write_reg(ENC_ADDR, u8tc_pkg::DATA_W'(u8tc_pkg::ENC_LATIN1));
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();
		write_reg(ENC_ADDR, u8tc_pkg::DATA_W'(u8tc_pkg::ENC_UTF16LE));
		foreach (LE_SEQ[i])
			send_byte(LE_SEQ[i], i == 15);
		settle();
		write_reg(BLANK_ADDR, '1);
		write_reg(ENC_ADDR, '1);
		send_byte(8'h12, 1'b1);

		random_start = items_sent;
		phase = 0;
		while (items_sent < random_start + RANDOM_ITEMS) begin
			settle();
			if (phase < 4)
				mode = u8tc_pkg::enc_t'(3 - phase);
			else
				mode = u8tc_pkg::enc_t'($urandom_range(0, 3));
			write_reg(ENC_ADDR, ($urandom & 32'hFFFF_FFFC) | u8tc_pkg::DATA_W'(mode));
			cur_enc = mode;
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 35;
			endcase
			texts = $urandom_range(1, 3);
			for (int t = 0; t < texts; t++) begin
				if (cur_enc == u8tc_pkg::ENC_UTF16LE || cur_enc == u8tc_pkg::ENC_UTF16BE)
					send_utf16_text((t < texts - 1) || ($urandom_range(0, 3) != 0));
				else
					send_byte_text((t < texts - 1) || ($urandom_range(0, 3) != 0));
				if (items_sent >= random_start + CALM_ITEMS)
					calm = 1;
			end
			phase++;
		end

		settle();
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_utf16_latin1_to_utf8_transcoder: done, clean");
		else
			$display("tb_utf16_latin1_to_utf8_transcoder: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/u8tc_pkg.sv
rtl/u8tc_front.sv
rtl/u8tc_queue.sv
rtl/u8tc_back.sv
rtl/utf16_latin1_to_utf8_transcoder.sv
dv/tb_utf16_latin1_to_utf8_transcoder.sv
